### src/phvc_pkg.sv
// Package for the position-hold velocity controller.
// Holds shared constants, opcodes, register indexes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package phvc_pkg;

    // Default coordinate width for stored positions and targets.
    localparam int COORD_WIDTH_DEF = 32;

    // Stream payload widths (fields packed from bit 0, padded to bytes).
    localparam int IN_TDATA_W  = 112;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_STAB_BIT = 96;

    // Configuration port.
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 48;

    // Reset values of the configuration registers.
    localparam logic [31:0] VEL_LIMIT_RST    = 32'd32768;
    localparam logic [47:0] MATRIX_ROW_X_RST = 48'h0000_0000_4000;
    localparam logic [47:0] MATRIX_ROW_Y_RST = 48'h0000_4000_0000;
    localparam logic [47:0] MATRIX_ROW_Z_RST = 48'h4000_0000_0000;

    // Shared arithmetic widths.
    localparam int DIV_W     = 64;
    localparam int DIVISOR_W = 32;
    localparam int ROOT_W    = 32;
    localparam int MAT_EW    = 16;
    localparam int MUL_AW    = 17;
    localparam int CR_W      = 31;

    // Control values of the pilot switch.
    localparam logic [7:0] CTRL_PASSIVE = 8'd0;
    localparam logic [7:0] CTRL_STAB_A  = 8'd1;
    localparam logic [7:0] CTRL_STAB_B  = 8'd2;
    localparam logic [7:0] CTRL_NONE    = 8'd255;

    typedef enum logic [2:0] {
        OP_POSE      = 3'd0,
        OP_CONTROL   = 3'd1,
        OP_SET_SHIFT = 3'd2,
        OP_ADD_SHIFT = 3'd3,
        OP_LINK      = 3'd4
    } op_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_VEL_LIMIT = 2'd0,
        REG_ROW_X     = 2'd1,
        REG_ROW_Y     = 2'd2,
        REG_ROW_Z     = 2'd3
    } cfg_reg_t;

    typedef enum logic [15:0] {
        ST_IDLE        = 16'h0001,
        ST_DIV_GO      = 16'h0002,
        ST_DIV_WAIT    = 16'h0004,
        ST_NORM        = 16'h0008,
        ST_SQ_MUL      = 16'h0010,
        ST_SQ_ACC      = 16'h0020,
        ST_SQRT_GO     = 16'h0040,
        ST_SQRT_WAIT   = 16'h0080,
        ST_LIM_CHK     = 16'h0100,
        ST_LM_MUL      = 16'h0200,
        ST_LM_ACC      = 16'h0400,
        ST_LM_DIV_GO   = 16'h0800,
        ST_LM_DIV_WAIT = 16'h1000,
        ST_MAT_MUL     = 16'h2000,
        ST_MAT_ACC     = 16'h4000,
        ST_FINISH      = 16'h8000
    } state_t;

endpackage

### src/position_hold_velocity_controller.sv
// Position-hold velocity controller: a small sequencer around one shared
// multiplier, a bit-serial divider and a bit-serial square root.
// Depends on phvc_pkg, phvc_mul, phvc_div and phvc_sqrt.
`timescale 1ns / 1ps

// Every transaction on the input stream yields exactly one result transaction.
// Control, shift and link items, and poses in passive mode, are handled in the
// cycle they are taken and their result is offered on the next cycle. A pose in
// stabilized mode runs the full control law: three shift-and-add divisions by
// ten for the 0.4 gain, a normalising step plus one shift per excess bit (up
// to COORD_WIDTH-31 shifts), multiplier passes for the squared norm, a square
// root, a limit check, and when the norm is above the limit three passes of
// product and division by the root, then the matrix product and a last step
// to load the result. s_tready is low while that runs. Configuration must only
// be written while the block is idle.
module position_hold_velocity_controller import phvc_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_AW-1:0]      cfg_addr,
    input  logic [CFG_DW-1:0]      cfg_wdata,
    // Input stream.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // coord_x[31:0], coord_y[63:32], coord_z[95:64], control_value[103:96], armed[104]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // opcode[2:0]
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // vel_x[31:0], vel_y[63:32], vel_z[95:64], stabilized[96]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // setpoint_valid[0]
    output logic                   m_tuser
);

    localparam int CW   = COORD_WIDTH;
    localparam int BW   = (CW > 33) ? CW : 33;
    localparam int ACCW = (BW + 19 > 66) ? BW + 19 : 66;
    localparam int SUMW = ((CW > 32) ? CW : 32) + 2;
    localparam int NW   = CW + 4;
    localparam int SHW  = $clog2(CW + 1);
    localparam int PW   = MUL_AW + BW;

    // Saturate a widened sum to the coordinate width.
    function automatic logic signed [CW-1:0] sat_w(input logic signed [SUMW-1:0] v);
        logic signed [SUMW-1:0] hi;
        logic signed [SUMW-1:0] lo;
        hi = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return hi[CW-1:0];
        end else if (v < lo) begin
            return lo[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    // Saturate the accumulator to a signed 32-bit velocity.
    function automatic logic signed [31:0] sat32(input logic signed [ACCW-1:0] v);
        logic signed [ACCW-1:0] hi;
        logic signed [ACCW-1:0] lo;
        hi = {{(ACCW-31){1'b0}}, {31{1'b1}}};
        lo = ~hi;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // Configuration registers.
    logic [31:0] vel_limit_reg;
    logic [47:0] row_reg [3];

    // Controller state.
    state_t               state_reg, state_next;
    logic                 mode_reg, mode_next;
    logic                 armed_reg, armed_next;
    logic [7:0]           prev_ctrl_reg, prev_ctrl_next;
    logic signed [CW-1:0] tgt_reg [3];
    logic signed [CW-1:0] tgt_next [3];
    logic signed [CW-1:0] last_reg [3];
    logic signed [CW-1:0] last_next [3];

    // Working registers of the control law.
    logic [1:0]             idx_reg, idx_next;
    logic [1:0]             jdx_reg, jdx_next;
    logic                   half_reg, half_next;
    logic [SHW-1:0]         s_reg, s_next;
    logic signed [BW-1:0]   c_reg [3];
    logic signed [BW-1:0]   c_next [3];
    logic [CW-1:0]          mag_reg [3];
    logic [CW-1:0]          mag_next [3];
    logic signed [ACCW-1:0] acc_reg, acc_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic signed [31:0]     vel_reg [3];
    logic signed [31:0]     vel_next [3];
    logic [NW-1:0]          dq_reg, dq_next;
    logic [2:0]             dstep_reg, dstep_next;
    logic                   dfix_reg, dfix_next;

    // Output register.
    logic               m_valid_reg, m_valid_next;
    logic               m_setp_reg, m_setp_next;
    logic               m_stab_reg, m_stab_next;
    logic signed [31:0] m_vel_reg [3];
    logic signed [31:0] m_vel_next [3];

    // Shared unit connections.
    logic                     mul_en;
    logic signed [MUL_AW-1:0] mul_a;
    logic signed [BW-1:0]     mul_b;
    logic signed [PW-1:0]     mul_p;
    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [DIVISOR_W-1:0]     div_divisor;
    logic                     div_done;
    logic [DIV_W-1:0]         div_q;
    logic                     sqrt_start;
    logic                     sqrt_done;
    logic [ROOT_W-1:0]        sqrt_root;

    // Input fields.
    op_t                    in_op;
    logic signed [SUMW-1:0] in_v [3];
    logic [7:0]             in_ctrl;
    logic                   in_armed;
    logic                   s_fire;
    logic                   out_free;

    // Helper values of the sequencer.
    logic signed [CW:0]     diff;
    logic signed [NW-1:0]   n_val;
    logic                   n_neg;
    logic [NW-1:0]          n_abs;
    logic [NW-1:0]          gain_q;
    logic [DIV_W-1:0]       mag_ext;
    logic [CR_W-1:0]        cr_sel;
    logic [CW-1:0]          mag_or;
    logic [DIV_W-1:0]       norm_val;
    logic signed [ACCW-1:0] p_ext;
    logic signed [ACCW-1:0] acc_sum;
    logic signed [ACCW-1:0] acc_rnd;
    logic [MAT_EW-1:0]      entry;

    assign in_op    = op_t'(s_tuser);
    assign in_v[0]  = SUMW'($signed(s_tdata[31:0]));
    assign in_v[1]  = SUMW'($signed(s_tdata[63:32]));
    assign in_v[2]  = SUMW'($signed(s_tdata[95:64]));
    assign in_ctrl  = s_tdata[103:96];
    assign in_armed = s_tdata[104];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_tvalid && s_tready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_limit_reg <= VEL_LIMIT_RST;
            row_reg[0]    <= MATRIX_ROW_X_RST;
            row_reg[1]    <= MATRIX_ROW_Y_RST;
            row_reg[2]    <= MATRIX_ROW_Z_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_VEL_LIMIT: vel_limit_reg <= cfg_wdata[31:0];
                REG_ROW_X:     row_reg[0]    <= cfg_wdata;
                REG_ROW_Y:     row_reg[1]    <= cfg_wdata;
                REG_ROW_Z:     row_reg[2]    <= cfg_wdata;
                default:       vel_limit_reg <= vel_limit_reg;
            endcase
        end
    end

    // Shared units.
    phvc_mul #(.BW(BW)) u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    phvc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    phvc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (acc_reg[DIV_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Rounded gain term of the selected axis: floor((4d + 5) / 10).
    always_comb begin
        diff    = (CW+1)'(tgt_reg[idx_reg]) - (CW+1)'(last_reg[idx_reg]);
        n_val   = (NW'(diff) <<< 2) + NW'(5);
        n_neg   = n_val[NW-1];
        n_abs   = n_neg ? NW'(NW'(9) - n_val) : n_val;
        gain_q  = dq_reg + NW'(dfix_reg);
        mag_ext = DIV_W'(mag_reg[idx_reg]);
        cr_sel  = mag_ext[CR_W-1:0];
        mag_or  = mag_reg[0] | mag_reg[1] | mag_reg[2];
        norm_val = DIV_W'(root_reg) << s_reg;
        p_ext   = ACCW'(mul_p);
        acc_sum = acc_reg + (half_reg ? (p_ext <<< 16) : p_ext);
        acc_rnd = (acc_reg + p_ext + ACCW'(2**13)) >>> 14;
        case (jdx_reg)
            2'd0:    entry = row_reg[idx_reg][15:0];
            2'd1:    entry = row_reg[idx_reg][31:16];
            default: entry = row_reg[idx_reg][47:32];
        endcase
    end

    // Shared unit operand selection.
    always_comb begin
        mul_en       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = acc_reg[DIV_W-1:0];
        div_divisor  = root_reg;
        sqrt_start   = (state_reg == ST_SQRT_GO);
        unique case (state_reg)
            ST_SQ_MUL: begin
                mul_en = 1'b1;
                mul_a  = half_reg ? MUL_AW'(cr_sel[CR_W-1:16]) : MUL_AW'(cr_sel[15:0]);
                mul_b  = BW'(cr_sel);
            end
            ST_LM_MUL: begin
                mul_en = 1'b1;
                mul_a  = half_reg ? MUL_AW'(cr_sel[CR_W-1:16]) : MUL_AW'(cr_sel[15:0]);
                mul_b  = BW'(vel_limit_reg);
            end
            ST_LM_DIV_GO: begin
                div_start = 1'b1;
            end
            ST_MAT_MUL: begin
                mul_en = 1'b1;
                mul_a  = MUL_AW'($signed(entry));
                mul_b  = c_reg[jdx_reg];
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Sequencer and item handling.
    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        armed_next     = armed_reg;
        prev_ctrl_next = prev_ctrl_reg;
        idx_next       = idx_reg;
        jdx_next       = jdx_reg;
        half_next      = half_reg;
        s_next         = s_reg;
        acc_next       = acc_reg;
        root_next      = root_reg;
        dq_next        = dq_reg;
        dstep_next     = dstep_reg;
        dfix_next      = dfix_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_setp_next    = m_setp_reg;
        m_stab_next    = m_stab_reg;
        for (int i = 0; i < 3; i++) begin
            tgt_next[i]   = tgt_reg[i];
            last_next[i]  = last_reg[i];
            c_next[i]     = c_reg[i];
            mag_next[i]   = mag_reg[i];
            vel_next[i]   = vel_reg[i];
            m_vel_next[i] = m_vel_reg[i];
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    // Items handled at once produce a result with no setpoint.
                    m_valid_next = 1'b1;
                    m_setp_next  = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        m_vel_next[i] = '0;
                    end
                    case (in_op)
                        OP_POSE: begin
                            for (int i = 0; i < 3; i++) begin
                                last_next[i] = sat_w(in_v[i]);
                            end
                            if (mode_reg) begin
                                m_valid_next = m_valid_reg && !m_tready;
                                idx_next     = '0;
                                s_next       = '0;
                                state_next   = ST_DIV_GO;
                            end
                        end
                        OP_CONTROL: begin
                            if (in_ctrl != prev_ctrl_reg) begin
                                if (in_ctrl == CTRL_STAB_A || in_ctrl == CTRL_STAB_B) begin
                                    mode_next = 1'b1;
                                    for (int i = 0; i < 3; i++) begin
                                        tgt_next[i] = '0;
                                    end
                                end else if (in_ctrl == CTRL_PASSIVE) begin
                                    mode_next = 1'b0;
                                end
                            end
                            prev_ctrl_next = in_ctrl;
                        end
                        OP_SET_SHIFT: begin
                            for (int i = 0; i < 3; i++) begin
                                tgt_next[i] = sat_w(SUMW'(last_reg[i]) + in_v[i]);
                            end
                        end
                        OP_ADD_SHIFT: begin
                            for (int i = 0; i < 3; i++) begin
                                tgt_next[i] = sat_w(SUMW'(tgt_reg[i]) + in_v[i]);
                            end
                        end
                        OP_LINK: begin
                            // A rising armed edge drops the target.
                            if (!armed_reg && in_armed) begin
                                for (int i = 0; i < 3; i++) begin
                                    tgt_next[i] = '0;
                                end
                            end
                            armed_next = in_armed;
                        end
                        default: begin
                            armed_next = armed_reg;
                        end
                    endcase
                    m_stab_next = mode_next;
                end
            end
            ST_DIV_GO: begin
                // First estimate of 8n / 10 as n * 0.75, refined towards n * 0.8.
                dq_next    = (n_abs >> 1) + (n_abs >> 2);
                dstep_next = '0;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                // Refine the estimate, divide by eight and fix the last unit.
                dstep_next = dstep_reg + 1'b1;
                case (dstep_reg)
                    3'd0: dq_next = dq_reg + (dq_reg >> 4);
                    3'd1: dq_next = dq_reg + (dq_reg >> 8);
                    3'd2: dq_next = dq_reg + (dq_reg >> 16);
                    3'd3: dq_next = dq_reg + (dq_reg >> 32);
                    3'd4: dq_next = dq_reg >> 3;
                    3'd5: dfix_next = (n_abs - ((dq_reg << 3) + (dq_reg << 1))) >= NW'(10);
                    default: begin
                        c_next[idx_reg]   = n_neg ? -BW'(gain_q) : BW'(gain_q);
                        mag_next[idx_reg] = gain_q[CW-1:0];
                        if (idx_reg == 2'd2) begin
                            state_next = ST_NORM;
                        end else begin
                            idx_next   = idx_reg + 1'b1;
                            state_next = ST_DIV_GO;
                        end
                    end
                endcase
            end
            ST_NORM: begin
                // Shift all magnitudes down until each fits in 31 bits.
                if ((DIV_W'(mag_or) >> CR_W) != '0) begin
                    for (int i = 0; i < 3; i++) begin
                        mag_next[i] = mag_reg[i] >> 1;
                    end
                    s_next = s_reg + 1'b1;
                end else begin
                    idx_next   = '0;
                    half_next  = 1'b0;
                    acc_next   = '0;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: begin
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                acc_next = acc_sum;
                if (!half_reg) begin
                    half_next  = 1'b1;
                    state_next = ST_SQ_MUL;
                end else begin
                    half_next = 1'b0;
                    if (idx_reg == 2'd2) begin
                        state_next = ST_SQRT_GO;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SQ_MUL;
                    end
                end
            end
            ST_SQRT_GO: begin
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    root_next  = sqrt_root;
                    state_next = ST_LIM_CHK;
                end
            end
            ST_LIM_CHK: begin
                // Below the limit the gain terms already fit the coordinate width.
                idx_next  = '0;
                jdx_next  = '0;
                half_next = 1'b0;
                acc_next  = '0;
                if (norm_val > DIV_W'(vel_limit_reg)) begin
                    state_next = ST_LM_MUL;
                end else begin
                    state_next = ST_MAT_MUL;
                end
            end
            ST_LM_MUL: begin
                state_next = ST_LM_ACC;
            end
            ST_LM_ACC: begin
                acc_next = acc_sum;
                if (!half_reg) begin
                    half_next  = 1'b1;
                    state_next = ST_LM_MUL;
                end else begin
                    half_next  = 1'b0;
                    state_next = ST_LM_DIV_GO;
                end
            end
            ST_LM_DIV_GO: begin
                state_next = ST_LM_DIV_WAIT;
            end
            ST_LM_DIV_WAIT: begin
                if (div_done) begin
                    c_next[idx_reg] = c_reg[idx_reg][BW-1] ? -BW'(div_q) : BW'(div_q);
                    acc_next        = '0;
                    if (idx_reg == 2'd2) begin
                        idx_next   = '0;
                        jdx_next   = '0;
                        state_next = ST_MAT_MUL;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_LM_MUL;
                    end
                end
            end
            ST_MAT_MUL: begin
                state_next = ST_MAT_ACC;
            end
            ST_MAT_ACC: begin
                acc_next = acc_reg + p_ext;
                if (jdx_reg == 2'd2) begin
                    vel_next[idx_reg] = sat32(acc_rnd);
                    acc_next          = '0;
                    jdx_next          = '0;
                    if (idx_reg == 2'd2) begin
                        state_next = ST_FINISH;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_MAT_MUL;
                    end
                end else begin
                    jdx_next   = jdx_reg + 1'b1;
                    state_next = ST_MAT_MUL;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_setp_next  = 1'b1;
                    m_stab_next  = mode_reg;
                    for (int i = 0; i < 3; i++) begin
                        m_vel_next[i] = vel_reg[i];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= 1'b0;
            armed_reg     <= 1'b0;
            prev_ctrl_reg <= CTRL_NONE;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                tgt_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            armed_reg     <= armed_next;
            prev_ctrl_reg <= prev_ctrl_next;
            m_valid_reg   <= m_valid_next;
            for (int i = 0; i < 3; i++) begin
                tgt_reg[i]  <= tgt_next[i];
                last_reg[i] <= last_next[i];
            end
        end
    end

    // Working and output payload registers.
    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        jdx_reg    <= jdx_next;
        half_reg   <= half_next;
        s_reg      <= s_next;
        acc_reg    <= acc_next;
        root_reg   <= root_next;
        dq_reg     <= dq_next;
        dstep_reg  <= dstep_next;
        dfix_reg   <= dfix_next;
        m_setp_reg <= m_setp_next;
        m_stab_reg <= m_stab_next;
        for (int i = 0; i < 3; i++) begin
            c_reg[i]     <= c_next[i];
            mag_reg[i]   <= mag_next[i];
            vel_reg[i]   <= vel_next[i];
            m_vel_reg[i] <= m_vel_next[i];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_setp_reg;
    assign m_tdata  = {7'd0, m_stab_reg, m_vel_reg[2], m_vel_reg[1], m_vel_reg[0]};

endmodule

### src/phvc_mul.sv
// Shared signed multiplier of the controller with a registered product.
// Depends on phvc_pkg for the narrow operand width.
`timescale 1ns / 1ps

module phvc_mul import phvc_pkg::*; #(
    parameter int BW = 33
) (
    input  logic                         aclk,
    input  logic                         en,
    input  logic signed [MUL_AW-1:0]     a,
    input  logic signed [BW-1:0]         b,
    output logic signed [MUL_AW+BW-1:0]  p
);

    logic signed [MUL_AW+BW-1:0] p_reg;

    // One product per issue; the result is ready on the following cycle.
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

### src/phvc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on phvc_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps

module phvc_div import phvc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    output logic                 done,
    output logic [DIV_W-1:0]     quotient
);

    localparam int CW_CNT = $clog2(DIV_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CW_CNT-1:0]    cnt_reg;
    logic [DIV_W-1:0]     dvd_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W:0]   rem_sh;
    logic                 q_bit;

    // Shift in the next dividend bit and try a subtraction.
    assign rem_sh = {rem_reg, dvd_reg[DIV_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, dsr_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW_CNT'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the quotient bits replace the dividend bits as they leave.
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            if (q_bit) begin
                rem_reg <= DIVISOR_W'(rem_sh - {1'b0, dsr_reg});
            end else begin
                rem_reg <= rem_sh[DIVISOR_W-1:0];
            end
            dvd_reg <= {dvd_reg[DIV_W-2:0], q_bit};
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

### src/phvc_sqrt.sv
// Integer square root of a 64-bit value, one result bit per cycle.
// Depends on phvc_pkg for the operand and root widths.
`timescale 1ns / 1ps

module phvc_sqrt import phvc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DIV_W-1:0]  n_reg;
    logic [DIV_W-1:0]  res_reg;
    logic [DIV_W-1:0]  bit_reg;
    logic [DIV_W-1:0]  trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Digit-by-digit root: one trial subtraction per bit pair.
    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= {2'b01, {(DIV_W-2){1'b0}}};
        end else if (busy_reg) begin
            if (n_reg >= trial) begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

### src/phvc_checker.sv
// Port-level checker for the position-hold velocity controller, bound to the top.
// Depends on phvc_pkg for the stream widths.
`timescale 1ns / 1ps

module phvc_checker import phvc_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser
);

    // No result is offered straight after reset.
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

    // A setpoint is only produced in stabilized mode.
    a_setp_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[OUT_STAB_BIT])
        else $error("setpoint in passive mode");

    // Without a setpoint the velocity fields are zero.
    a_zero_vel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[OUT_STAB_BIT-1:0] == '0)
        else $error("velocity without setpoint");

    // A stalled result transaction holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // The input is never taken while a result waits and is not being taken.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid || m_tready)
        else $error("input taken over a waiting result");

endmodule

bind position_hold_velocity_controller phvc_checker u_phvc_checker (.*);
